// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clk_i.
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk_i.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/i2ctpb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target packet buffer package
// Event codes, protocol phases, result type and default sizes.
// ----------------------------------------------------------------------------
package i2ctpb_pkg;

  localparam int unsigned BufferDepthDefault = 64;
  localparam int unsigned ByteW              = 8;

  // Decoded bus events.
  typedef enum logic [2:0] {
    OP_WRITE_ADDR = 3'd0,
    OP_BYTE_RX    = 3'd1,
    OP_STOP       = 3'd2,
    OP_READ_ADDR  = 3'd3,
    OP_SENT_ACK   = 3'd4,
    OP_SENT_NACK  = 3'd5,
    OP_BUS_ERROR  = 3'd6,
    OP_OTHER      = 3'd7
  } op_e;

  // Protocol phase as reported on the result.
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ADDRESSED = 3'd1,
    PH_POINTER   = 3'd2,
    PH_PACKET    = 3'd3,
    PH_SENDING   = 3'd4
  } phase_e;

  // Response bytes written after a packet check.
  localparam logic [ByteW-1:0] RespPass0 = 8'h01;
  localparam logic [ByteW-1:0] RespPass1 = 8'hFE;
  localparam logic [ByteW-1:0] RespFail0 = 8'hFF;
  localparam logic [ByteW-1:0] RespFail1 = 8'hEE;
  localparam logic [ByteW-1:0] RespInit0 = 8'h07;
  localparam logic [ByteW-1:0] RespInit1 = 8'h09;

  typedef struct packed {
    logic [ByteW-1:0] tx_data;
    logic             tx_valid;
    phase_e           phase;
    logic             packet_done;
    logic             checksum_ok;
    logic             pointer_fault;
  } res_t;

endpackage

// ----- sv/i2ctpb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module i2ctpb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/i2c_target_packet_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target packet buffer
// Back end of an I2C target: pointer-addressed receive buffer, packet
// checksum check and a two-byte response read back by the controller.
// ----------------------------------------------------------------------------
// Every decoded bus event (one input item) yields exactly one result item.
// Events are taken one at a time. Most events finish in the cycle they are
// accepted, so their result is on the output register in the next cycle.
// A stop that ends a packet (a stop while a pointer has been received) walks
// the receive RAM through its single read port to sum the checksum: ST_LEN
// takes byte 0 as the length, ending the check if it is invalid, and ST_SUM
// then sums the bytes before the last one and checks the last against ~sum.
// A fresh event can be accepted while the previous result is being taken by
// the downstream side. The receive RAM has no clearing pass: a valid bit per
// entry, cleared by reset, makes unwritten entries read as zero, so the block
// is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module i2c_target_packet_buffer
  import i2ctpb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Event input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation
  // Result output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] tx_data, [10:8] proto_state,
                                      // [11] packet_done, [12] checksum_ok,
                                      // [13] pointer_fault, [15:14] zero
  output logic [0:0]  m_axis_tuser    // [0] tx_valid
);

`include "assert_macros.svh"

  localparam int unsigned AW     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam logic [8:0]  DepthW = 9'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(BUFFER_DEPTH - 1);

  // Sequencer for the packet check.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_SUM
  } ctl_e;

  ctl_e              st_q, st_d;
  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  wp_q, wp_d;
  logic [AW-1:0]     rp_q, rp_d;
  logic [ByteW-1:0]  resp0_q, resp0_d;
  logic [ByteW-1:0]  resp1_q, resp1_d;
  logic [BUFFER_DEPTH-1:0] vld_q, vld_d;
  logic              rd_vld_q, rd_vld_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     lenm1_q, lenm1_d;
  logic [ByteW-1:0]  sum_q, sum_d;
  logic              m_valid_q, m_valid_d;
  res_t              m_res_q, m_res_d;

  logic              accept;
  logic              out_free;
  logic              load;
  logic              chk_done;
  res_t              res;
  op_e               op;
  logic [ByteW-1:0]  din;
  logic [ByteW-1:0]  rd_byte;
  logic [ByteW-1:0]  len;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ByteW-1:0]  ram_rdata;

  assign op       = op_e'(s_axis_tuser);
  assign din      = s_axis_tdata;
  assign out_free = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) && out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // An entry never written since reset reads as zero.
  assign rd_byte = rd_vld_q ? ram_rdata : '0;
  assign len     = rd_byte;

  always_comb begin
    st_d      = st_q;
    phase_d   = phase_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    resp0_d   = resp0_q;
    resp1_d   = resp1_q;
    vld_d     = vld_q;
    rd_vld_d  = rd_vld_q;
    cnt_d     = cnt_q;
    lenm1_d   = lenm1_q;
    sum_d     = sum_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    load      = 1'b0;
    chk_done  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wp_q[AW-1:0];
    ram_re    = 1'b0;
    ram_raddr = '0;
    res       = '{tx_data: '0, tx_valid: 1'b0, phase: PH_IDLE,
                  packet_done: 1'b0, checksum_ok: 1'b0, pointer_fault: 1'b0};

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          unique case (op)
            OP_WRITE_ADDR: begin
              phase_d = PH_ADDRESSED;
            end
            OP_BYTE_RX: begin
              if (phase_q == PH_ADDRESSED) begin
                wp_d    = din;
                phase_d = PH_POINTER;
              end else if (phase_q == PH_POINTER) begin
                if ({1'b0, wp_q} < DepthW) begin
                  ram_we           = 1'b1;
                  vld_d[ram_waddr] = 1'b1;
                  wp_d = ({1'b0, wp_q} == DepthW - 9'd1) ? '0 : wp_q + 8'd1;
                end else begin
                  res.pointer_fault = 1'b1;
                end
              end
            end
            OP_STOP: begin
              if (phase_q == PH_POINTER) begin
                // Fetch the length byte; the result follows the check.
                load      = 1'b0;
                ram_re    = 1'b1;
                ram_raddr = '0;
                rd_vld_d  = vld_q[0];
                st_d      = ST_LEN;
              end else begin
                phase_d = PH_IDLE;
              end
            end
            OP_READ_ADDR, OP_SENT_ACK: begin
              res.tx_valid = 1'b1;
              if (rp_q == AW'(0)) begin
                res.tx_data = resp0_q;
              end else if (rp_q == AW'(1)) begin
                res.tx_data = resp1_q;
              end
              rp_d    = (rp_q == LastIdx) ? '0 : rp_q + AW'(1);
              phase_d = PH_SENDING;
            end
            OP_SENT_NACK, OP_BUS_ERROR, OP_OTHER: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
      ST_LEN: begin
        if (len == '0 || {1'b0, len} > DepthW) begin
          chk_done = 1'b1;
        end else begin
          lenm1_d   = AW'(len - 8'd1);
          cnt_d     = '0;
          sum_d     = '0;
          ram_re    = 1'b1;
          ram_raddr = '0;
          rd_vld_d  = vld_q[0];
          st_d      = ST_SUM;
        end
      end
      ST_SUM: begin
        if (cnt_q == lenm1_q) begin
          // The expected byte is -(sum + 1), which is the complement of sum.
          chk_done        = 1'b1;
          res.checksum_ok = (rd_byte == ~sum_q);
        end else begin
          sum_d     = sum_q + rd_byte;
          cnt_d     = cnt_q + AW'(1);
          ram_re    = 1'b1;
          ram_raddr = cnt_q + AW'(1);
          rd_vld_d  = vld_q[ram_raddr];
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (chk_done) begin
      load            = 1'b1;
      res.packet_done = 1'b1;
      phase_d         = PH_PACKET;
      rp_d            = '0;
      resp0_d         = res.checksum_ok ? RespPass0 : RespFail0;
      resp1_d         = res.checksum_ok ? RespPass1 : RespFail1;
      st_d            = ST_IDLE;
    end

    res.phase = phase_d;
    m_res_d   = load ? res : m_res_q;
    if (load) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      phase_q   <= PH_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      resp0_q   <= RespInit0;
      resp1_q   <= RespInit1;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      phase_q   <= phase_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      resp0_q   <= resp0_d;
      resp1_q   <= resp1_d;
      vld_q     <= vld_d;
      rd_vld_q  <= rd_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    lenm1_q <= lenm1_d;
    sum_q   <= sum_d;
    m_res_q <= m_res_d;
  end

  // Receive buffer. Writes happen only on bytes in ST_IDLE, check reads on a
  // stop or outside ST_IDLE, so the ports never touch the same entry together.
  i2ctpb_ram #(
    .WIDTH (ByteW),
    .DEPTH (BUFFER_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (din),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_res_q.pointer_fault, m_res_q.checksum_ok,
                          m_res_q.packet_done, m_res_q.phase, m_res_q.tx_data};
  assign m_axis_tuser  = m_res_q.tx_valid;

  `AST_IMPL(a_busy_blocks_input, st_q != ST_IDLE, !s_axis_tready,
            "event accepted while a packet check is running")
  `AST_IMPL(a_check_output_free, chk_done, !m_valid_q,
            "packet check finished while the output register was occupied")
  `AST_IMPL(a_write_in_range, ram_we, {1'b0, wp_q} < DepthW,
            "receive buffer written with an out-of-range pointer")
  `AST_NEXT(a_check_result, chk_done,
            m_valid_q && m_res_q.packet_done && m_res_q.phase == PH_PACKET,
            "packet check did not produce a completed-packet result")

endmodule

// ----- dv/tb_i2c_target_packet_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C target packet buffer testbench
// Sends decoded bus events into the block and checks every result item
// against a cycle-free model of the pointer, packet store, checksum and
// response read-back.
// ----------------------------------------------------------------------------
// A queue of bus events is filled by the sequencing process. A driver on the
// falling edge offers them on the event stream, and a sink on the falling
// edge drives tready. On the rising edge every accepted event advances the
// model, and every accepted result is compared with the oldest predicted one.
// The run has a short directed part followed by random traffic, which is
// mostly well-formed packet writes and response reads, in three idling
// regimes. A watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module tb_i2c_target_packet_buffer;
  import i2ctpb_pkg::*;

  localparam int unsigned DEPTH      = BufferDepthDefault;
  // A long stop walks up to DEPTH bytes; the sink's long hold-off is the
  // slowest thing in the run, so the limit is set well clear of both.
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT = 2 * DEPTH + 20;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } bus_event_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data
  logic [2:0]  s_axis_tuser = '0;   // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] tx_data, [10:8] proto_state,
                                    // [11] packet_done, [12] checksum_ok,
                                    // [13] pointer_fault, [15:14] zero
  logic [0:0]  m_axis_tuser;        // [0] tx_valid

  i2c_target_packet_buffer #(
    .BUFFER_DEPTH(DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Events waiting to be offered, and results predicted but not yet seen.
  bus_event_t event_q[$];
  res_t       outcome_q[$];

  int unsigned events_queued = 0;
  int unsigned mismatches    = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_idle_pct  = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  logic        event_fire    = 1'b0;

  // Model state: the phase, the two pointers and the two byte stores.
  phase_e     bus_phase;
  logic [7:0] wr_ptr;
  logic [5:0] rd_ptr;
  logic [7:0] rx_bytes[DEPTH];
  logic [7:0] reply_bytes[DEPTH];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  task automatic clear_model();
    bus_phase = PH_IDLE;
    wr_ptr    = '0;
    rd_ptr    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rx_bytes[i]    = '0;
      reply_bytes[i] = '0;
    end
    reply_bytes[0] = RespInit0;
    reply_bytes[1] = RespInit1;
  endtask

  // The packet passes when byte 0 is a usable length and the byte at the end
  // of the packet equals minus (sum of the bytes before it, plus one).
  function automatic logic packet_passes();
    int unsigned len;
    logic [7:0]  sum;
    len = rx_bytes[0];
    sum = '0;
    if (len == 0 || len > DEPTH) return 1'b0;
    for (int unsigned i = 0; i + 1 < len; i++) sum += rx_bytes[i];
    return rx_bytes[len-1] == 8'(-(sum + 8'd1));
  endfunction

  task automatic apply_bus_event(input op_e op, input logic [7:0] data, output res_t r);
    r = '0;
    case (op)
      OP_WRITE_ADDR: bus_phase = PH_ADDRESSED;
      OP_BYTE_RX: begin
        // A byte in any other phase is simply ignored.
        if (bus_phase == PH_ADDRESSED) begin
          wr_ptr    = data;
          bus_phase = PH_POINTER;
        end else if (bus_phase == PH_POINTER) begin
          if (wr_ptr < DEPTH) begin
            rx_bytes[wr_ptr] = data;
            wr_ptr = 8'((wr_ptr + 1) % DEPTH);
          end else begin
            r.pointer_fault = 1'b1;
          end
        end
      end
      OP_STOP: begin
        if (bus_phase == PH_POINTER) begin
          bus_phase     = PH_PACKET;
          r.packet_done = 1'b1;
          r.checksum_ok = packet_passes();
          reply_bytes[0] = r.checksum_ok ? RespPass0 : RespFail0;
          reply_bytes[1] = r.checksum_ok ? RespPass1 : RespFail1;
          rd_ptr = '0;
        end else begin
          bus_phase = PH_IDLE;
        end
      end
      OP_READ_ADDR, OP_SENT_ACK: begin
        r.tx_data  = reply_bytes[rd_ptr];
        r.tx_valid = 1'b1;
        rd_ptr     = rd_ptr + 6'd1;
        bus_phase  = PH_SENDING;
      end
      default: bus_phase = PH_IDLE;
    endcase
    r.phase = bus_phase;
  endtask

  // --------------------------------------------------------------------------
  // Event driver: a new item is put up only once the current one is taken.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || event_fire)) begin
      if (event_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= event_q[0].op;
        s_axis_tdata  <= event_q[0].data;
        void'(event_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink. A long hold-off, once asked for, is counted down here while
  // the driver keeps offering, so the block backs up and stalls its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_asked != holds_served) begin
      holds_served  <= holds_served + 1;
      hold_left     <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Prediction and checking at the rising edge. A result taken at the same
  // edge as an event belongs to an earlier event, so it is checked first.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    res_t next;
    if (m_axis_tvalid && m_axis_tready) begin
      got.tx_data       = m_axis_tdata[7:0];
      got.phase         = phase_e'(m_axis_tdata[10:8]);
      got.packet_done   = m_axis_tdata[11];
      got.checksum_ok   = m_axis_tdata[12];
      got.pointer_fault = m_axis_tdata[13];
      got.tx_valid      = m_axis_tuser[0];
      if (outcome_q.size() == 0) begin
        $error("result item arrived with no event waiting for it");
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("tx_data", want.tx_data, got.tx_data);
        check_field("tx_valid", want.tx_valid, got.tx_valid);
        check_field("proto_state", want.phase, got.phase);
        check_field("packet_done", want.packet_done, got.packet_done);
        check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
        check_field("pointer_fault", want.pointer_fault, got.pointer_fault);
        check_field("tdata pad", 0, m_axis_tdata[15:14]);
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      apply_bus_event(op_e'(s_axis_tuser), s_axis_tdata, next);
      outcome_q.push_back(next);
    end
    event_fire <= s_axis_tvalid && s_axis_tready;
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  task automatic add_event(input op_e op, input logic [7:0] data);
    bus_event_t ev;
    ev.op   = op;
    ev.data = data;
    event_q.push_back(ev);
    events_queued++;
  endtask

  // A packet write: addressing, pointer, length byte, body and (usually) the
  // right checksum, then mostly a stop. Pointers are mostly zero so that the
  // length and checksum land where the check reads them.
  task automatic add_packet();
    int unsigned r;
    int unsigned ptr;
    int unsigned len;
    int unsigned nbytes;
    logic [7:0]  sum;
    logic [7:0]  b;
    r   = $urandom_range(99);
    ptr = (r < 85) ? 0 : (r < 95) ? $urandom_range(1, DEPTH - 1) : $urandom_range(DEPTH, 255);
    r   = $urandom_range(99);
    len = (r < 75) ? $urandom_range(1, 10) : (r < 92) ? $urandom_range(11, 40) :
          (r < 97) ? $urandom_range(41, DEPTH) : $urandom_range(0, 255);
    nbytes = (len == 0 || len > DEPTH) ? $urandom_range(1, 4) : len;
    add_event(OP_WRITE_ADDR, 8'($urandom));
    add_event(OP_BYTE_RX, 8'(ptr));
    sum = '0;
    for (int unsigned i = 0; i < nbytes; i++) begin
      if (i == 0) b = 8'(len);
      else if (i == nbytes - 1 && $urandom_range(9) != 0) b = 8'(-(sum + 8'd1));
      else b = 8'($urandom);
      add_event(OP_BYTE_RX, b);
      sum += b;
    end
    // Now and then a few extra bytes run past the packet.
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 3)) add_event(OP_BYTE_RX, 8'($urandom));
    end
    if ($urandom_range(9) != 0) add_event(OP_STOP, 8'($urandom));
    else add_event(op_e'($urandom_range(7)), 8'($urandom));
  endtask

  // A read of the response; occasionally long enough to wrap the pointer.
  task automatic add_readback();
    int unsigned acks;
    int unsigned r;
    acks = ($urandom_range(9) == 0) ? $urandom_range(DEPTH - 4, DEPTH + 6) : $urandom_range(0, 4);
    add_event(OP_READ_ADDR, 8'($urandom));
    repeat (acks) add_event(OP_SENT_ACK, 8'($urandom));
    r = $urandom_range(9);
    if (r < 7) add_event(OP_SENT_NACK, 8'($urandom));
    else if (r < 9) add_event(OP_STOP, 8'($urandom));
    else add_event(OP_BYTE_RX, 8'($urandom));
  endtask

  task automatic add_random(input int unsigned count);
    int unsigned goal;
    int unsigned r;
    goal = events_queued + count;
    while (events_queued < goal) begin
      r = $urandom_range(99);
      if (r < 55) begin
        add_packet();
        if ($urandom_range(9) < 7) add_readback();
      end else if (r < 75) begin
        add_readback();
      end else begin
        repeat ($urandom_range(1, 3)) add_event(op_e'($urandom_range(7)), 8'($urandom));
      end
    end
  endtask

  task automatic wait_events_taken();
    do @(negedge clk_i); while (event_q.size() != 0 || s_axis_tvalid);
  endtask

  task automatic wait_results_in();
    do @(negedge clk_i); while (outcome_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run
  // --------------------------------------------------------------------------
  initial begin
    clear_model();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Stray byte and stop while idle, read of the reset
    // response, a byte while sending, then a packet that passes.
    add_event(OP_BYTE_RX, 8'hFF);
    add_event(OP_STOP, 8'h00);
    add_event(OP_READ_ADDR, 8'h00);
    add_event(OP_SENT_ACK, 8'hFF);
    add_event(OP_BYTE_RX, 8'h5A);
    add_event(OP_SENT_NACK, 8'h00);
    add_event(OP_WRITE_ADDR, 8'hFF);
    add_event(OP_BYTE_RX, 8'h00);
    add_event(OP_BYTE_RX, 8'h03);
    add_event(OP_BYTE_RX, 8'h55);
    add_event(OP_BYTE_RX, 8'hA7);
    add_event(OP_STOP, 8'hFF);
    // A byte after the packet is complete is ignored; then read the reply.
    add_event(OP_BYTE_RX, 8'h11);
    add_event(OP_READ_ADDR, 8'hFF);
    add_event(OP_SENT_ACK, 8'h00);
    // Pointer far out of range: the byte is dropped and flagged.
    add_event(OP_WRITE_ADDR, 8'h00);
    add_event(OP_BYTE_RX, 8'hFF);
    add_event(OP_BYTE_RX, 8'h00);
    add_event(OP_BUS_ERROR, 8'hFF);
    // Pointer at the last entry: the second byte wraps into byte 0 and
    // gives a length above the depth, so the check fails.
    add_event(OP_WRITE_ADDR, 8'h00);
    add_event(OP_BYTE_RX, 8'(DEPTH - 1));
    add_event(OP_BYTE_RX, 8'hAA);
    add_event(OP_BYTE_RX, 8'h80);
    add_event(OP_STOP, 8'h00);
    // A zero length fails too.
    add_event(OP_WRITE_ADDR, 8'h00);
    add_event(OP_BYTE_RX, 8'h00);
    add_event(OP_BYTE_RX, 8'h00);
    add_event(OP_STOP, 8'h00);
    add_event(OP_OTHER, 8'hFF);

    // The sender pauses here until every result has come back.
    wait_events_taken();
    wait_results_in();

    @(posedge clk_i);
    src_idle_pct = 20;
    snk_idle_pct = 61;
    add_random(530);
    wait_events_taken();

    @(posedge clk_i);
    src_idle_pct = 61;
    snk_idle_pct = 20;
    add_random(530);
    wait_events_taken();

    // No idling at all, with one long hold-off by the sink at the start.
    @(posedge clk_i);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    holds_asked  = holds_asked + 1;
    add_random(530);
    wait_events_taken();
    wait_results_in();
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (outcome_q.size() != 0) begin
      $error("%0d predicted results never arrived", outcome_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
